// ===== sv/fpadd_pkg.sv =====
`default_nettype none
package fpadd_pkg;
    localparam int SIG_BITS_DEF = 24;
    localparam int EXP_BITS_DEF = 8;
    localparam int EXTRA_BITS = 3;
    localparam int WORD_BITS = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic       sign_l;
        logic       same_sign;
        logic [7:0] exp_l;
        logic [7:0] diff;
        logic [23:0] sig_l;
        logic [23:0] sig_s;
    } fpadd_front_t;
endpackage
`default_nettype wire

// ===== sv/fp32_adder_rne_unit.sv =====
// channel | signals                           | word
// in      | in_valid, in_ready                | operand_a, operand_b
// out     | out_valid, out_ready              | sum_word, overflow_flag
// One pair accepted per cycle while in_ready is high; the steps are classify into
// queue, align/add, normalize/round. A two-entry queue parts the classifier from
// the adder pipe. Reset clears all valid bits; no item is held across reset.
// A stall at the output backs up the pipe and then the queue before in_ready drops.
`default_nettype none
module fp32_adder_rne_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] operand_a,
    input  wire logic [31:0] operand_b,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      sum_word,
    output logic             overflow_flag
);
    import fpadd_pkg::*;

    logic         q_valid, q_ready;
    fpadd_front_t q_data;

    fpadd_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .operand_a(operand_a), .operand_b(operand_b),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    fpadd_back u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_data(q_data), .valid(out_valid), .ready(out_ready),
        .sum_word(sum_word), .overflow_flag(overflow_flag)
    );
endmodule
`default_nettype wire

// ===== sv/fpadd_front.sv =====
`default_nettype none
module fpadd_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [31:0]          operand_a,
    input  wire logic [31:0]          operand_b,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output fpadd_pkg::fpadd_front_t   q_data
);
    import fpadd_pkg::*;

    logic [QUEUE_DEPTH-1:0] vld_reg;
    fpadd_front_t           ent_reg [QUEUE_DEPTH];
    fpadd_front_t           cls;
    logic [31:0]            big, sml;
    logic [7:0]             el, es;
    logic                   pop, push;

    always_comb
    begin
        if (operand_a[30:0] >= operand_b[30:0])
        begin
            big = operand_a;
            sml = operand_b;
        end
        else
        begin
            big = operand_b;
            sml = operand_a;
        end
        el = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
        cls.sign_l    = big[31];
        cls.same_sign = big[31] == sml[31];
        cls.exp_l     = el;
        cls.diff      = el - es;
        cls.sig_l     = {big[30:23] != 8'd0, big[22:0]};
        cls.sig_s     = {sml[30:23] != 8'd0, sml[22:0]};
    end

    // two-entry queue: slot 0 is head
    assign q_valid  = vld_reg[0];
    assign q_data   = ent_reg[0];
    assign pop      = q_valid && q_ready;
    assign in_ready = !vld_reg[1] || pop;
    assign push     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (pop)
            vld_reg <= {push && vld_reg[1], vld_reg[1] || push};
        else if (push)
            vld_reg <= {vld_reg[0], 1'b1};
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg[0] <= vld_reg[1] ? ent_reg[1] : cls;
            ent_reg[1] <= cls;
        end
        else if (push)
        begin
            if (vld_reg[0])
                ent_reg[1] <= cls;
            else
                ent_reg[0] <= cls;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) vld_reg[1] |-> vld_reg[0])
        else $error("queue slot order broken");
    assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[1] && !pop) |-> !in_ready)
        else $error("accept while full");
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && !q_ready) |=> q_valid)
        else $error("queue head lost");
endmodule
`default_nettype wire

// ===== sv/fpadd_back.sv =====
`default_nettype none
module fpadd_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    output logic                      q_ready,
    input  wire fpadd_pkg::fpadd_front_t q_data,
    output logic                      valid,
    input  wire logic                 ready,
    output logic [31:0]               sum_word,
    output logic                      overflow_flag
);
    import fpadd_pkg::*;

    // stage 1: align and add
    logic        v1_reg;
    logic        s1_reg, same1_reg;
    logic [9:0]  e1_reg;
    logic [27:0] sum1_reg;
    // stage 2: normalize, round, pack
    logic        v2_reg;
    logic [31:0] w2_reg;
    logic        ovf2_reg;

    logic        adv1, adv2;
    logic [26:0] a_l, a_s, sh;
    logic [4:0]  d;
    logic        lost;
    logic [27:0] sum;

    assign adv2    = !v2_reg || ready;
    assign adv1    = !v1_reg || adv2;
    assign q_ready = adv1;

    always_comb
    begin
        a_l = {q_data.sig_l, 3'b000};
        a_s = {q_data.sig_s, 3'b000};
        d = (q_data.diff > 8'd27) ? 5'd27 : q_data.diff[4:0];
        sh = a_s >> d;
        lost = (a_s & ~({27{1'b1}} << d)) != 27'd0;
        sh[0] = sh[0] | lost;
        if (q_data.same_sign)
            sum = {1'b0, a_l} + {1'b0, sh};
        else
            sum = {1'b0, a_l} - {1'b0, sh};
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && q_valid)
        begin
            s1_reg    <= q_data.sign_l;
            same1_reg <= q_data.same_sign;
            e1_reg    <= {2'b00, q_data.exp_l};
            sum1_reg  <= sum;
        end
    end

    logic [4:0]  lz;
    logic [27:0] nrm;
    logic [9:0]  e;
    logic [24:0] m;
    logic [31:0] w;
    logic        ovf;
    logic [9:0]  room;
    logic        found;

    always_comb
    begin
        lz = 5'd0;
        found = 1'b0;
        for (int i = 26; i >= 0; i--)
        begin
            if (!found && sum1_reg[i])
            begin
                found = 1'b1;
                lz = 5'(26 - i);
            end
        end
        room = e1_reg - 10'd1;
        if (room < {5'd0, lz})
            lz = room[4:0];
        e = e1_reg;
        nrm = sum1_reg;
        if (sum1_reg[27])
        begin
            nrm = {1'b0, sum1_reg[27:2], sum1_reg[1] | sum1_reg[0]};
            e = e1_reg + 10'd1;
        end
        else
        begin
            nrm = sum1_reg << lz;
            e = e1_reg - {5'd0, lz};
        end
        m = {1'b0, nrm[26:3]};
        if (nrm[2] && (nrm[1] || nrm[0] || m[0]))
            m = m + 25'd1;
        if (m[24])
        begin
            m = m >> 1;
            e = e + 10'd1;
        end
        ovf = 1'b0;
        if (sum1_reg == 28'd0)
            w = {same1_reg & s1_reg, 31'd0};
        else if (e >= 10'd255)
        begin
            ovf = 1'b1;
            w = {s1_reg, 8'hFF, 23'd0};
        end
        else
            w = {s1_reg, m[23] ? e[7:0] : 8'd0, m[22:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= q_valid;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            w2_reg   <= w;
            ovf2_reg <= ovf;
        end
    end

    assign valid         = v2_reg;
    assign sum_word      = w2_reg;
    assign overflow_flag = ovf2_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !ready) |=> valid)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && overflow_flag) |-> (sum_word[30:0] == {8'hFF, 23'd0}))
        else $error("overflow word malformed");
    assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !adv2) |=> v1_reg)
        else $error("stage one lost");
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    localparam int LIMIT_CYCLES = 4000;
    localparam int N_RANDOM = 1750;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
    } pair_t;

    typedef struct {
        logic [31:0] word;
        logic        ovf;
    } sum_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] operand_a = '0;
    logic [31:0] operand_b = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] sum_word;
    logic        overflow_flag;

    pair_t pending_pairs[$];
    sum_t  expected_sums[$];
    int    error_count = 0;
    int    idle_cycles = 0;
    int    send_wait = 0;
    int    recv_wait = 0;
    int    hold_off = 0;
    bit    stimulus_done = 1'b0;

    fp32_adder_rne_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .operand_a(operand_a), .operand_b(operand_b),
        .out_valid(out_valid), .out_ready(out_ready),
        .sum_word(sum_word), .overflow_flag(overflow_flag)
    );

    always #2 clk = ~clk;

    // Shift right, folding every lost bit into bit 0.
    function automatic logic [27:0] shr_sticky(logic [27:0] x, int d);
        logic [27:0] lost;
        if (d == 0)
            return x;
        lost = x & ((28'd1 << d) - 28'd1);
        return (x >> d) | {27'd0, lost != 0};
    endfunction

    function automatic sum_t fp_add_rne(logic [31:0] wa, logic [31:0] wb);
        logic [31:0] big, little;
        logic        sign_l, sign_s;
        int          exp_l, exp_s, e, d;
        logic [27:0] sig_l, sig_s, sum;
        logic [24:0] m;
        logic [2:0]  grs;
        sum_t        r;
        if (wa[30:0] >= wb[30:0])
        begin
            big = wa;
            little = wb;
        end
        else
        begin
            big = wb;
            little = wa;
        end
        sign_l = big[31];
        sign_s = little[31];
        exp_l = big[30:23];
        exp_s = little[30:23];
        sig_l = {5'd0, big[22:0]};
        sig_s = {5'd0, little[22:0]};
        if (exp_l == 0) exp_l = 1; else sig_l[23] = 1'b1;
        if (exp_s == 0) exp_s = 1; else sig_s[23] = 1'b1;
        sig_l = sig_l << 3;
        sig_s = sig_s << 3;
        d = exp_l - exp_s;
        if (d > 27) d = 27;
        sig_s = shr_sticky(sig_s, d);
        sum = (sign_l == sign_s) ? sig_l + sig_s : sig_l - sig_s;
        r.ovf = 1'b0;
        if (sum == 0)
        begin
            r.word = (sign_l == sign_s) ? {sign_l, 31'd0} : 32'd0;
            return r;
        end
        e = exp_l;
        if (sum[27])
        begin
            sum = shr_sticky(sum, 1);
            e++;
        end
        else
        begin
            while (!sum[26] && e > 1)
            begin
                sum = sum << 1;
                e--;
            end
        end
        grs = sum[2:0];
        m = {1'b0, sum[26:3]};
        if (grs[2] && (grs[1:0] != 0 || m[0]))
            m++;
        if (m[24])
        begin
            m = m >> 1;
            e++;
        end
        if (e >= 255)
        begin
            r.ovf = 1'b1;
            r.word = {sign_l, 8'hFF, 23'd0};
        end
        else
        begin
            r.word = {sign_l, m[23] ? e[7:0] : 8'd0, m[22:0]};
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        error_count++;
    endtask

    function automatic logic [31:0] rand_float();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 5))
            0: w[30:23] = 8'd0;
            1: w[30:23] = 8'($urandom_range(250, 255));
            2: w[22:0] = $urandom_range(0, 3) == 0 ? 23'd0 : 23'h7FFFFF;
            default: ;
        endcase
        return w;
    endfunction

    task automatic add_pair(logic [31:0] a, logic [31:0] b);
        pair_t p;
        p.a = a;
        p.b = b;
        pending_pairs = {pending_pairs, p};
    endtask

    initial
    begin
        logic [31:0] a, b;
        add_pair(32'h0000_0000, 32'h0000_0000);
        add_pair(32'h8000_0000, 32'h8000_0000);
        add_pair(32'h3F80_0000, 32'hBF80_0000);     // exact cancel to +0
        add_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF);     // overflow
        add_pair(32'hFF80_0000, 32'h3F80_0000);     // all-ones exponent
        add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_pair(32'h3F80_0000, 32'h0000_0001);     // saturated alignment
        add_pair(32'h0000_0001, 32'h0000_0001);     // subnormals
        add_pair(32'h007F_FFFF, 32'h0000_0001);     // subnormal becomes normal
        add_pair(32'h0080_0000, 32'h8000_0001);     // tiny result
        add_pair(32'h3F80_0000, 32'h3380_0000);     // tie, round to even
        add_pair(32'h3F80_0001, 32'h3380_0000);     // tie, round up
        add_pair(32'h3FFF_FFFF, 32'h3400_0000);     // significand carry-out
        add_pair(32'h4000_0000, 32'hB3FF_FFFF);
        add_pair(32'h7F00_0000, 32'h7F00_0000);
        add_pair(32'h1234_5678, 32'h9234_5679);
        add_pair(32'hFFFF_FFFF, 32'h0000_0000);
        for (int i = 0; i < N_RANDOM; i++)
        begin
            a = rand_float();
            b = rand_float();
            if ($urandom_range(0, 7) == 0)
                b = {~a[31], a[30:0] ^ (31'd1 << $urandom_range(0, 4))};
            if ($urandom_range(0, 9) == 0)
                b[30:23] = a[30:23] - 8'($urandom_range(0, 30));
            add_pair(a, b);
        end
        stimulus_done = 1'b1;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: hold the word until accepted, then wait a random gap.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_sums = {expected_sums, fp_add_rne(operand_a, operand_b)};
                send_wait = $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (pending_pairs.size() > 0)
                begin
                    pair_t p;
                    p = pending_pairs.pop_front();
                    operand_a <= p.a;
                    operand_b <= p.b;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted word, stall at random, once for a long stretch.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_sums.size() == 0)
                begin
                    report_mismatch("unexpected word", sum_word, 32'd0);
                end
                else
                begin
                    sum_t x;
                    x = expected_sums.pop_front();
                    if (sum_word !== x.word)
                        report_mismatch("sum_word", sum_word, x.word);
                    if (overflow_flag !== x.ovf)
                        report_mismatch("overflow_flag", {31'd0, overflow_flag},
                                        {31'd0, x.ovf});
                end
                recv_wait = $urandom_range(0, 3) == 0 ? $urandom_range(0, 17) : 0;
                if (hold_off == 0 && expected_sums.size() == 0 && pending_pairs.size() > 0
                        && pending_pairs.size() < 1500)
                    hold_off = 1;
            end
            if (hold_off > 0 && hold_off < 60)
            begin
                hold_off++;
                out_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT_CYCLES)
        begin
            $display("[fp32_adder_rne_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        wait (stimulus_done);
        wait (pending_pairs.size() == 0 && !in_valid && expected_sums.size() == 0);
        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_sums.size() == 0)
            $display("[fp32_adder_rne_unit] OK");
        else
            $display("[fp32_adder_rne_unit] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
